// File: sv/arpc_pkg.sv
package arpc_pkg;

  localparam int CacheEntriesDef = 128;
  localparam int PendingSlotsDef = 16;

  localparam logic [11:0] TimeoutRst  = 12'd15;
  localparam logic [3:0]  MaxSendsRst = 4'd5;
  localparam logic [7:0]  GapRst      = 8'd1;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_QUEUE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_QUEUED  = 3'd1,
    KIND_INSERT  = 3'd2,
    KIND_SEND    = 3'd3,
    KIND_GIVEUP  = 3'd4,
    KIND_TICK    = 3'd5
  } kind_t;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_SENDS   = 2'd1;
  localparam logic [1:0] REG_GAP     = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CSCAN,    // walk cache entries
    ST_PSCAN,    // walk pending slots
    ST_EMIT,     // present final result
    ST_TCACHE,   // tick: age cache
    ST_TPEND,    // tick: visit pending slot
    ST_TOUT      // tick: present send/give-up
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch input item, clear scan
    logic cstep;     // advance cache index
    logic pstep;     // advance pending index
    logic q_commit;  // commit queue write
    logic i_commit;  // commit insert
    logic tick_inc;  // bump seconds
    logic age_step;  // age one cache entry
    logic tp_act;    // act on current pending slot
    logic ld_final;  // load final result
    logic ld_tick;   // load per-slot tick result
    logic out_take;  // result consumed
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;      // latched command
    logic [1:0] in_cmd;   // command on the input port
    logic       c_end;
    logic       p_end;
    logic       slot_due;
  } dp_sts_t;

endpackage

// File: sv/arpc_ctrl.sv
module arpc_ctrl
  import arpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    out_fire,
  input  dp_sts_t sts,
  output logic    in_ready,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) begin
        unique case (cmd_t'(sts.in_cmd))
          CMD_LOOKUP: state_next = ST_CSCAN;
          CMD_QUEUE:  state_next = ST_PSCAN;
          CMD_INSERT: state_next = ST_PSCAN;
          CMD_TICK:   state_next = ST_TCACHE;
        endcase
      end
      ST_PSCAN: if (sts.p_end)
        state_next = (cmd_t'(sts.cmd) == CMD_INSERT) ? ST_CSCAN : ST_EMIT;
      ST_CSCAN:  if (sts.c_end) state_next = ST_EMIT;
      ST_EMIT:   if (out_fire) state_next = ST_IDLE;
      ST_TCACHE: if (sts.c_end) state_next = ST_TPEND;
      ST_TPEND: begin
        if (sts.slot_due)   state_next = ST_TOUT;
        else if (sts.p_end) state_next = ST_EMIT;
      end
      ST_TOUT: if (out_fire) state_next = sts.p_end ? ST_EMIT : ST_TPEND;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT) || (state == ST_TOUT);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.start = in_fire;
        cmd.tick_inc = in_fire && (cmd_t'(sts.in_cmd) == CMD_TICK);
      end
      ST_PSCAN: begin
        cmd.pstep = 1'b1;
        if (sts.p_end) begin
          cmd.q_commit = (cmd_t'(sts.cmd) == CMD_QUEUE);
          cmd.ld_final = (cmd_t'(sts.cmd) == CMD_QUEUE);
        end
      end
      ST_CSCAN: begin
        cmd.cstep = 1'b1;
        if (sts.c_end) begin
          cmd.i_commit = (cmd_t'(sts.cmd) == CMD_INSERT);
          cmd.ld_final = 1'b1;
        end
      end
      ST_TCACHE: cmd.age_step = 1'b1;
      ST_TPEND: begin
        cmd.ld_tick = sts.slot_due;
        cmd.tp_act  = sts.slot_due;
        cmd.pstep   = !sts.slot_due;
        cmd.ld_final = !sts.slot_due && sts.p_end;
      end
      ST_EMIT: begin
        cmd.out_take = out_fire;
      end
      ST_TOUT: begin
        cmd.out_take = out_fire;
        cmd.pstep    = out_fire;
        cmd.ld_final = out_fire && sts.p_end;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready) else $error("accept while busy");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && out_fire |=> state == ST_IDLE) else $error("emit exit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_fire |=> out_valid) else $error("result dropped");
`endif

endmodule

// File: sv/arpc_dp.sv
module arpc_dp
  import arpc_pkg::*;
#(
  parameter int CacheEntries = CacheEntriesDef,
  parameter int PendingSlots = PendingSlotsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_ip,
  input  logic [47:0] in_mac,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [11:0] cfg_data,
  output logic [2:0]  o_kind,
  output logic        o_hit,
  output logic [31:0] o_ip,
  output logic [47:0] o_mac,
  output logic        o_full,
  output logic        o_last
);

  localparam int CW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int PW = (PendingSlots > 1) ? $clog2(PendingSlots) : 1;
  localparam logic [CW:0] CLast = (CW+1)'(CacheEntries - 1);
  localparam logic [PW:0] PLast = (PW+1)'(PendingSlots - 1);

  logic [11:0] timeout;
  logic [3:0]  max_sends;
  logic [7:0]  gap;
  logic [31:0] now;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TimeoutRst; max_sends <= MaxSendsRst; gap <= GapRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TIMEOUT: timeout   <= cfg_data;
        REG_SENDS:   max_sends <= cfg_data[3:0];
        REG_GAP:     gap       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // cache: valid in flops, payload in memory
  logic [CacheEntries-1:0] mvalid;
  logic [31:0] map_ip    [CacheEntries];
  logic [47:0] map_mac   [CacheEntries];
  logic [31:0] map_stamp [CacheEntries];
  logic [PendingSlots-1:0] pvalid;
  logic [31:0] pend_ip    [PendingSlots];
  logic [31:0] pend_stamp [PendingSlots];
  logic [3:0]  pend_tries [PendingSlots];

  logic [1:0]  r_cmd;
  logic [31:0] r_ip;
  logic [47:0] r_mac;
  logic [CW-1:0] ci;
  logic [PW-1:0] pi;
  logic found, pfree_ok, cfree_ok;
  logic [47:0] got;
  logic [PW-1:0] pfree;
  logic [CW-1:0] cfree;
  logic had;

  logic [31:0] cur_ip, cur_stamp, m_ip, m_stamp;
  logic [47:0] m_mac;
  logic [3:0]  cur_tries;
  logic [CW-1:0] rd_ci;
  assign cur_ip    = pend_ip[pi];
  assign cur_stamp = pend_stamp[pi];
  assign cur_tries = pend_tries[pi];

  logic [31:0] p_age, m_age;
  assign p_age = now - cur_stamp;
  assign m_age = now - m_stamp;

  always_comb begin
    sts.cmd      = r_cmd;
    sts.in_cmd   = in_cmd;
    sts.c_end    = ({1'b0, ci} == CLast);
    sts.p_end    = ({1'b0, pi} == PLast);
    sts.slot_due = pvalid[pi] && (cur_tries == 4'd0 || p_age > {24'd0, gap});
  end

  // read address runs one step ahead, so m_* hold entry ci during the walk
  always_comb begin
    rd_ci = ci;
    if (cmd.start) rd_ci = '0;
    else if ((cmd.cstep || cmd.age_step) && !sts.c_end) rd_ci = ci + CW'(1);
  end

  always_ff @(posedge clk) begin
    m_ip    <= map_ip[rd_ci];
    m_mac   <= map_mac[rd_ci];
    m_stamp <= map_stamp[rd_ci];
  end

  logic q_dup, q_free, i_free, i_had;
  assign q_dup  = had || (pvalid[pi] && cur_ip == r_ip);
  assign q_free = pfree_ok || !pvalid[pi];
  assign i_free = cfree_ok || !mvalid[ci];
  assign i_had  = had;

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid <= '0; pvalid <= '0; now <= '0;
    end else begin
      if (cmd.tick_inc) now <= now + 32'd1;
      if (cmd.age_step && mvalid[ci] && m_age > {20'd0, timeout}) mvalid[ci] <= 1'b0;
      if (cmd.pstep && r_cmd == CMD_INSERT && pvalid[pi] && cur_ip == r_ip && !had)
        pvalid[pi] <= 1'b0;
      if (cmd.q_commit && !q_dup && q_free) pvalid[pfree_ok ? pfree : pi] <= 1'b1;
      if (cmd.i_commit && (cfree_ok || !mvalid[ci])) begin
        mvalid[cfree_ok ? cfree : ci] <= 1'b1;
      end
      if (cmd.tp_act && cur_tries >= max_sends) pvalid[pi] <= 1'b0;
    end
  end

  // memories and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_cmd <= in_cmd; r_ip <= in_ip; r_mac <= in_mac;
      ci <= '0; pi <= '0; found <= 1'b0; got <= '0;
      pfree_ok <= 1'b0; cfree_ok <= 1'b0; had <= 1'b0;
      pfree <= '0; cfree <= '0;
    end else begin
      if (cmd.cstep || cmd.age_step) begin
        if (r_cmd == CMD_LOOKUP && mvalid[ci] && m_ip == r_ip) begin
          found <= 1'b1; got <= m_mac;
        end
        if (!mvalid[ci] && !cfree_ok) begin
          cfree_ok <= 1'b1; cfree <= ci;
        end
        if (!sts.c_end) ci <= ci + CW'(1);
      end
      if (cmd.pstep) begin
        if (pvalid[pi] && cur_ip == r_ip && r_cmd != CMD_TICK) had <= 1'b1;
        if (!pvalid[pi] && !pfree_ok) begin
          pfree_ok <= 1'b1; pfree <= pi;
        end
        if (!sts.p_end) pi <= pi + PW'(1);
      end
    end
    if (cmd.q_commit && !had && !(pvalid[pi] && cur_ip == r_ip)) begin
      if (pfree_ok || !pvalid[pi]) begin
        pend_ip[pfree_ok ? pfree : pi]    <= r_ip;
        pend_stamp[pfree_ok ? pfree : pi] <= '0;
        pend_tries[pfree_ok ? pfree : pi] <= '0;
      end
    end
    if (cmd.i_commit && (cfree_ok || !mvalid[ci])) begin
      map_ip[cfree_ok ? cfree : ci]    <= r_ip;
      map_mac[cfree_ok ? cfree : ci]   <= r_mac;
      map_stamp[cfree_ok ? cfree : ci] <= now;
    end
    if (cmd.tp_act && cur_tries < max_sends) begin
      pend_stamp[pi] <= now;
      pend_tries[pi] <= cur_tries + 4'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.ld_tick) begin
      o_kind <= (cur_tries >= max_sends) ? KIND_GIVEUP : KIND_SEND;
      o_hit <= 1'b0; o_ip <= cur_ip; o_mac <= '0; o_full <= 1'b0; o_last <= 1'b0;
    end else if (cmd.ld_final) begin
      o_ip <= '0; o_last <= 1'b1; o_hit <= 1'b0; o_mac <= '0; o_full <= 1'b0;
      unique case (cmd_t'(r_cmd))
        CMD_LOOKUP: begin
          o_kind <= KIND_LOOKUP;
          if (mvalid[ci] && m_ip == r_ip) begin
            o_hit <= 1'b1; o_mac <= m_mac;
          end else begin
            o_hit <= found; o_mac <= got;
          end
        end
        CMD_QUEUE: begin
          o_kind <= KIND_QUEUED; o_full <= !q_dup && !q_free;
        end
        CMD_INSERT: begin
          o_kind <= KIND_INSERT; o_hit <= i_had; o_full <= !i_free;
        end
        CMD_TICK: o_kind <= KIND_TICK;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_now: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_inc |=> now == $past(now) + 32'd1) else $error("time step");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.ld_tick, cmd.ld_final && !cmd.out_take})) else $error("load clash");
  a_give: assert property (@(posedge clk) disable iff (rst)
    cmd.tp_act && cur_tries >= max_sends |=> !pvalid[$past(pi)]) else $error("give up");
`endif

endmodule

// File: sv/arp_cache_with_request_retry.sv
// ARP cache with pending-request retry.
// Input stream s_axis: tuser = command, tdata = {mac_addr, ip_addr}; one
// transfer per command. Commands: lookup, queue request, insert mapping,
// one-second tick.
// Output stream m_axis: tuser = kind, tdata = {full_res, out_mac, out_ip, hit},
// tlast marks the final result of an item. A tick gives one result per due
// pending slot (send or give up), then a tick-done result.
// Each item walks its tables in order, a linear walk of the table with registered
// reads: lookup walks the cache; queue walks the pending slots; insert walks
// the pending slots, then the cache; tick ages the cache, then visits each
// pending slot. The single sequencer handles one item at a time:
// s_axis_tready rises the cycle after the last result of the previous item
// has been transferred.
// Reset (rst, synchronous) clears all valid bits and the seconds counter and
// loads register defaults; no clearing pass is needed.
// A stalled receiver (m_axis_tready low) holds the result and the sequencer.
// Configuration: cfg_we/cfg_idx/cfg_data; the user must write it only while idle, as the block does not enforce it.
module arp_cache_with_request_retry
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = CacheEntriesDef,
  parameter int PENDING_SLOTS = PendingSlotsDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // ip_addr[31:0], mac_addr[79:32]
  input  logic [1:0]   s_axis_tuser,   // command[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,   // hit[0], out_ip[32:1], out_mac[80:33],
                                       // full_res[81]
  output logic [2:0]   m_axis_tuser,   // kind[2:0]
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [11:0]  cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic in_fire, out_fire;
  logic        o_hit, o_full;
  logic [31:0] o_ip;
  logic [47:0] o_mac;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  arpc_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .sts,
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .cmd
  );

  arpc_dp #(.CacheEntries(CACHE_ENTRIES), .PendingSlots(PENDING_SLOTS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .in_cmd(s_axis_tuser), .in_ip(s_axis_tdata[31:0]),
    .in_mac(s_axis_tdata[79:32]),
    .cfg_we, .cfg_idx, .cfg_data,
    .o_kind(m_axis_tuser), .o_hit, .o_ip, .o_mac, .o_full, .o_last(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, o_full, o_mac, o_ip, o_hit};

endmodule
